// ===== rtl/separator_word_tokenizer_top_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the separator word tokenizer
// Clocked on i_clk, quiet while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef SEPARATOR_WORD_TOKENIZER_TOP_ASSERT_SVH
`define SEPARATOR_WORD_TOKENIZER_TOP_ASSERT_SVH

// Same-cycle implication.
`define SWT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("swt assertion failed");

// Next-cycle implication.
`define SWT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("swt assertion failed");

`endif

// ===== rtl/swt_pkg.sv =====
// ---------------------------------------------------------------------------
// swt_pkg
// Shared sizes, register indexes and types of the separator word tokenizer.
// ---------------------------------------------------------------------------
package swt_pkg;

    localparam int MAX_WORDS = 64;
    localparam int WORD_LEN  = 512;

    // Counters hold their limits: words up to MAX_WORDS, chars up to WORD_LEN + 1.
    localparam int WC_W = $clog2(MAX_WORDS + 1);
    localparam int CH_W = $clog2(WORD_LEN + 2);

    // Fixed field widths
    localparam int BYTE_W   = 8;
    localparam int WSLOT_W  = 6;
    localparam int CSLOT_W  = 9;
    localparam int WTOTAL_W = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_CNT_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEP_COUNT = 3'd0,
        CFG_SEP_A     = 3'd1,
        CFG_SEP_B     = 3'd2,
        CFG_SEP_C     = 3'd3,
        CFG_SEP_D     = 3'd4,
        CFG_COMMENT   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic is_sep;
        logic is_comment;
    } t_match;

    typedef struct packed {
        logic [BYTE_W-1:0]   out_byte;
        logic                byte_kept;
        logic [WSLOT_W-1:0]  word_slot;
        logic [CSLOT_W-1:0]  char_slot;
        logic                word_closed;
        logic                line_closed;
        logic [WTOTAL_W-1:0] words_total;
        logic                overflowed;
    } t_result;

endpackage

// ===== rtl/swt_in_if.sv =====
// ---------------------------------------------------------------------------
// swt_in_if
// Input byte channel: valid/ready with one text byte and its line flags.
// ---------------------------------------------------------------------------
interface swt_in_if import swt_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] text_byte;
    logic              line_last;
    logic              append_words;

    modport source (output valid, output text_byte, output line_last,
                    output append_words, input ready);
    modport sink   (input valid, input text_byte, input line_last,
                    input append_words, output ready);
endinterface

// ===== rtl/swt_out_if.sv =====
// ---------------------------------------------------------------------------
// swt_out_if
// Result channel: valid/ready with one tokenizer result per beat.
// ---------------------------------------------------------------------------
interface swt_out_if import swt_pkg::*;;
    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   out_byte;
    logic                byte_kept;
    logic [WSLOT_W-1:0]  word_slot;
    logic [CSLOT_W-1:0]  char_slot;
    logic                word_closed;
    logic                line_closed;
    logic [WTOTAL_W-1:0] words_total;
    logic                overflowed;

    modport source (output valid, output out_byte, output byte_kept, output word_slot,
                    output char_slot, output word_closed, output line_closed,
                    output words_total, output overflowed, input ready);
    modport sink   (input valid, input out_byte, input byte_kept, input word_slot,
                    input char_slot, input word_closed, input line_closed,
                    input words_total, input overflowed, output ready);
endinterface

// ===== rtl/swt_cfg_match.sv =====
// ---------------------------------------------------------------------------
// swt_cfg_match
// Configuration registers and the parallel separator / comment compares.
// ---------------------------------------------------------------------------
module swt_cfg_match import swt_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    input  logic [BYTE_W-1:0]    i_text_byte,
    output t_match               o_match
);

    logic [CFG_CNT_W-1:0] r_sep_count;
    logic [BYTE_W-1:0]    r_sep_a;
    logic [BYTE_W-1:0]    r_sep_b;
    logic [BYTE_W-1:0]    r_sep_c;
    logic [BYTE_W-1:0]    r_sep_d;
    logic [BYTE_W-1:0]    r_comment;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep_count <= CFG_CNT_W'(3);
            r_sep_a     <= BYTE_W'(32);
            r_sep_b     <= BYTE_W'(10);
            r_sep_c     <= BYTE_W'(9);
            r_sep_d     <= BYTE_W'(0);
            r_comment   <= BYTE_W'(35);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SEP_COUNT: r_sep_count <= i_cfg_data[CFG_CNT_W-1:0];
                CFG_SEP_A:     r_sep_a     <= i_cfg_data;
                CFG_SEP_B:     r_sep_b     <= i_cfg_data;
                CFG_SEP_C:     r_sep_c     <= i_cfg_data;
                CFG_SEP_D:     r_sep_d     <= i_cfg_data;
                CFG_COMMENT:   r_comment   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Counts above four enable all four registers.
    always_comb begin
        o_match.is_sep =
            ((r_sep_count >= CFG_CNT_W'(1)) && (i_text_byte == r_sep_a)) ||
            ((r_sep_count >= CFG_CNT_W'(2)) && (i_text_byte == r_sep_b)) ||
            ((r_sep_count >= CFG_CNT_W'(3)) && (i_text_byte == r_sep_c)) ||
            ((r_sep_count >= CFG_CNT_W'(4)) && (i_text_byte == r_sep_d));
        o_match.is_comment = (i_text_byte == r_comment);
    end

endmodule

// ===== rtl/swt_core.sv =====
// ---------------------------------------------------------------------------
// swt_core
// Line/word state, per-byte step logic and the registered result stage.
// ---------------------------------------------------------------------------
module swt_core import swt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_match   i_match,
    swt_in_if.sink   i_in,
    swt_out_if.source o_out
);

    logic            r_inside;
    logic            r_at_start;
    logic            r_comment;
    logic [WC_W-1:0] r_wc;
    logic [CH_W-1:0] r_ch;
    logic            r_ovf;

    logic            n_inside;
    logic            n_at_start;
    logic            n_comment;
    logic [WC_W-1:0] n_wc;
    logic [CH_W-1:0] n_ch;
    logic            n_ovf;

    logic    r_out_valid;
    t_result r_out;
    t_result n_out;
    logic    accept;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        logic            first;
        logic            kept;
        logic            closed;
        logic [WC_W-1:0] wslot;
        logic [CH_W-1:0] cslot;
        first  = r_at_start;
        kept   = 1'b0;
        closed = 1'b0;
        wslot  = '0;
        cslot  = '0;

        // Line start clears tracking; numbering restarts unless appending.
        n_wc       = (first && !i_in.append_words) ? '0 : r_wc;
        n_ovf      = first ? 1'b0 : r_ovf;
        n_inside   = first ? 1'b0 : r_inside;
        n_comment  = first ? 1'b0 : r_comment;
        n_ch       = first ? '0 : r_ch;
        n_at_start = 1'b0;

        if (!n_comment) begin
            priority if (first && i_match.is_comment) begin
                n_comment = 1'b1;
            end else if (i_match.is_sep) begin
                if (n_inside) begin
                    if (n_wc < WC_W'(MAX_WORDS) && n_ch <= CH_W'(WORD_LEN)) begin
                        n_wc   = n_wc + WC_W'(1);
                        closed = 1'b1;
                    end
                    n_inside = 1'b0;
                    n_ch     = '0;
                end
            end else if (i_match.is_comment) begin
                // Comment mid-line: drop the partial word.
                n_comment = 1'b1;
                n_inside  = 1'b0;
                n_ch      = '0;
            end else begin
                if (!n_inside) begin
                    n_inside = 1'b1;
                    n_ch     = '0;
                    if (n_wc >= WC_W'(MAX_WORDS)) begin
                        n_ovf = 1'b1;
                    end
                end
                if (n_wc < WC_W'(MAX_WORDS)) begin
                    if (n_ch < CH_W'(WORD_LEN)) begin
                        kept  = 1'b1;
                        wslot = n_wc;
                        cslot = n_ch;
                        n_ch  = n_ch + CH_W'(1);
                    end else begin
                        // Mark the word too long so it is not counted.
                        n_ch  = CH_W'(WORD_LEN + 1);
                        n_ovf = 1'b1;
                    end
                end
                if (i_in.line_last) begin
                    if (n_wc < WC_W'(MAX_WORDS) && n_ch <= CH_W'(WORD_LEN)) begin
                        n_wc   = n_wc + WC_W'(1);
                        closed = 1'b1;
                    end
                    n_inside = 1'b0;
                    n_ch     = '0;
                end
            end
        end

        if (i_in.line_last) begin
            n_at_start = 1'b1;
            n_inside   = 1'b0;
            n_comment  = 1'b0;
            n_ch       = '0;
        end

        n_out.out_byte    = i_in.text_byte;
        n_out.byte_kept   = kept;
        n_out.word_slot   = WSLOT_W'(wslot);
        n_out.char_slot   = CSLOT_W'(cslot);
        n_out.word_closed = closed;
        n_out.line_closed = i_in.line_last;
        n_out.words_total = WTOTAL_W'(n_wc);
        n_out.overflowed  = n_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside    <= 1'b0;
            r_at_start  <= 1'b1;
            r_comment   <= 1'b0;
            r_wc        <= '0;
            r_ch        <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_inside   <= n_inside;
                r_at_start <= n_at_start;
                r_comment  <= n_comment;
                r_wc       <= n_wc;
                r_ch       <= n_ch;
                r_ovf      <= n_ovf;
            end
            r_out_valid <= accept || (r_out_valid && !o_out.ready);
        end
    end

    // Result payload carries no reset; it is qualified by r_out_valid.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.out_byte    = r_out.out_byte;
    assign o_out.byte_kept   = r_out.byte_kept;
    assign o_out.word_slot   = r_out.word_slot;
    assign o_out.char_slot   = r_out.char_slot;
    assign o_out.word_closed = r_out.word_closed;
    assign o_out.line_closed = r_out.line_closed;
    assign o_out.words_total = r_out.words_total;
    assign o_out.overflowed  = r_out.overflowed;

endmodule

// ===== rtl/separator_word_tokenizer_top.sv =====
// ---------------------------------------------------------------------------
// separator_word_tokenizer_top
// Splits a text line, one byte per beat, into words on configurable separators.
// ---------------------------------------------------------------------------
// The block takes one byte per clock and returns one result beat per byte,
// in the cycle after the byte is accepted; a new byte can enter every cycle
// for as long as the result side keeps up. The single result register sits
// behind the per-byte compare-and-update logic. Bytes are split on up to four
// separator registers (separator_count selects how many, in order a..d;
// counts above four act as four). A comment byte as the first byte of a line
// gives an empty line; anywhere else it drops the partial word, and later
// bytes of that line are passed but not kept. A word longer than WORD_LEN
// bytes, or one that starts when MAX_WORDS words are already counted, is not
// counted and sets the overflow flag for that line. append_words on a line's
// first byte continues word numbering from the previous line. Configuration
// writes take effect at once and must be made while the block is idle. No
// clearing pass follows reset.
// ---------------------------------------------------------------------------
module separator_word_tokenizer_top import swt_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    swt_in_if.sink               i_in,
    swt_out_if.source            o_out
);

`include "separator_word_tokenizer_top_assert.svh"

    t_match match;

    // Separator and comment compares against the live input byte.
    swt_cfg_match u_cfg_match (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_text_byte (i_in.text_byte),
        .o_match     (match)
    );

    // State update and result register; ready drops only while a result stalls.
    swt_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_match (match),
        .i_in    (i_in),
        .o_out   (o_out)
    );

    // A byte outside any word reports zero slots.
    `SWT_ASSERT_NOW(a_unkept_zero_slots, o_out.valid && !o_out.byte_kept, o_out.word_slot == '0 && o_out.char_slot == '0)
    // A closed word means at least one word is counted.
    `SWT_ASSERT_NOW(a_closed_has_count, o_out.valid && o_out.word_closed, o_out.words_total != '0)
    // Hold off new bytes while a finished result waits.
    `SWT_ASSERT_NOW(a_stall_blocks_input, o_out.valid && !o_out.ready, !i_in.ready)
    // An accepted byte always shows up as a result beat next cycle.
    `SWT_ASSERT_NEXT(a_accept_gives_result, i_in.valid && i_in.ready, o_out.valid)

endmodule
